// ----- rtl/pixel_run_led_zone_averager_assert.svh -----
// Assertion macros for the LED zone averager.
`ifndef PIXEL_RUN_LED_ZONE_AVERAGER_ASSERT_SVH
`define PIXEL_RUN_LED_ZONE_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define PLZA_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication
`define PLZA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define PLZA_ASSERT_SAME(name, clk, rst, ante, cons)
`define PLZA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/plza_pkg.sv -----
package plza_pkg;

  localparam int LED_W      = 10;
  localparam int PIX_W      = 13;
  localparam int SUM_W      = 20;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 24;
  localparam int MAX_PIXELS = 4096;

  // zone numerator (led_count+1)*index stays below 1024*4096
  localparam int LEDP_W     = LED_W + 1;
  localparam int PROD_W     = LEDP_W + PIX_W;
  localparam int NUM_W      = 22;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER  = 2'd2;

  localparam logic [LED_W-1:0] LED_COUNT_RST   = 10'd192;
  localparam logic [PIX_W-1:0] PIXEL_COUNT_RST = 13'd1024;

  // what the shared divider is working on
  typedef enum logic [1:0] {
    DIV_ZONE,
    DIV_RED,
    DIV_GREEN,
    DIV_BLUE
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     accum;
    logic     div_start;
    div_sel_t div_sel;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_run;
    logic div_busy;
    logic div_done;
    logic zone_differs;
  } dp_status_t;

endpackage

// ----- rtl/pixel_run_led_zone_averager.sv -----
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
// pixels    in         in_valid/in_stall     pixel, first_pixel
// zones     out        out_valid/out_stall   led_index, led_color
//
// One pixel at a time. A pixel past the run end goes IDLE, CHECK and back to
// IDLE; a pixel in the run also waits on the 22-step shared divider forming
// the zone number. A pixel that closes a zone adds three more divisions for
// the means, plus any wait for the output register.
// Reset is synchronous; control, config and run registers return to their reset values, no sweep.
// A held result does not block input until the next zone end.
`include "pixel_run_led_zone_averager_assert.svh"

module pixel_run_led_zone_averager (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plza_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plza_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [plza_pkg::COLOR_W-1:0]     pixel,
  input  logic                             first_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [plza_pkg::LED_W-1:0]       led_index,
  output logic [plza_pkg::COLOR_W-1:0]     led_color
);

  plza_pkg::ctrl_cmd_t  cmd;
  plza_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  plza_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  plza_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .first_pixel (first_pixel),
    .cmd         (cmd),
    .sts         (sts),
    .led_index   (led_index),
    .led_color   (led_color)
  );

  // an accepted pixel locks the input until its work is done
  `PLZA_ASSERT_NEXT(a_lock_after_beat, clk, rst, in_valid && !in_stall, in_stall)
  // a result is written only into a free output register
  `PLZA_ASSERT_SAME(a_emit_slot_free, clk, rst, cmd.emit, !out_valid || !out_stall)
  // the divider is never restarted mid-division
  `PLZA_ASSERT_SAME(a_div_idle_at_start, clk, rst, cmd.div_start, !sts.div_busy)

endmodule

// ----- rtl/plza_div.sv -----
module plza_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plza_pkg::NUM_W-1:0]    dividend,
  input  logic [plza_pkg::PIX_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [plza_pkg::NUM_W-1:0]    quotient
);

  logic [plza_pkg::STEP_W-1:0] steps;
  logic [plza_pkg::PIX_W-1:0]  rem;
  logic [plza_pkg::NUM_W-1:0]  dq;
  logic [plza_pkg::PIX_W:0]    shifted;
  logic [plza_pkg::PIX_W:0]    diff;
  logic                        fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem, dq[plza_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= plza_pkg::STEP_W'(plza_pkg::DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == plza_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[plza_pkg::PIX_W-1:0] : shifted[plza_pkg::PIX_W-1:0];
      dq  <= {dq[plza_pkg::NUM_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

// ----- rtl/plza_datapath.sv -----
module plza_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [plza_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plza_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [plza_pkg::COLOR_W-1:0]      pixel,
  input  logic                              first_pixel,
  input  plza_pkg::ctrl_cmd_t               cmd,
  output plza_pkg::dp_status_t              sts,
  output logic [plza_pkg::LED_W-1:0]        led_index,
  output logic [plza_pkg::COLOR_W-1:0]      led_color
);

  logic [plza_pkg::LED_W-1:0]  led_count;
  logic [plza_pkg::PIX_W-1:0]  pixel_count;
  logic                        byte_order;

  logic [plza_pkg::PIX_W-1:0]  pixel_index;
  logic [plza_pkg::LED_W-1:0]  current_zone;
  logic [plza_pkg::SUM_W-1:0]  sum_red;
  logic [plza_pkg::SUM_W-1:0]  sum_green;
  logic [plza_pkg::SUM_W-1:0]  sum_blue;
  logic [plza_pkg::PIX_W-1:0]  sum_count;

  logic [plza_pkg::CH_W-1:0]   px_red;
  logic [plza_pkg::CH_W-1:0]   px_green;
  logic [plza_pkg::CH_W-1:0]   px_blue;
  logic [plza_pkg::NUM_W-1:0]  prod;
  logic [plza_pkg::LED_W-1:0]  new_zone;
  logic [plza_pkg::CH_W-1:0]   mean_red;
  logic [plza_pkg::CH_W-1:0]   mean_green;
  logic [plza_pkg::CH_W-1:0]   mean_blue;

  logic [plza_pkg::PIX_W-1:0]  run_len;
  logic [plza_pkg::PIX_W-1:0]  mean_div;
  logic [plza_pkg::LEDP_W-1:0] leds_p1;
  logic [plza_pkg::PROD_W-1:0] prod_full;
  logic [plza_pkg::NUM_W-1:0]  div_num;
  logic [plza_pkg::PIX_W-1:0]  div_den;
  logic [plza_pkg::NUM_W-1:0]  quotient;
  logic                        div_busy;
  logic                        div_done;

  function automatic logic [plza_pkg::SUM_W-1:0] sat_add(
    input logic [plza_pkg::SUM_W-1:0] acc,
    input logic [plza_pkg::CH_W-1:0]  v
  );
    logic [plza_pkg::SUM_W:0] s;
    s = {1'b0, acc} + {{(plza_pkg::SUM_W + 1 - plza_pkg::CH_W){1'b0}}, v};
    return s[plza_pkg::SUM_W] ? '1 : s[plza_pkg::SUM_W-1:0];
  endfunction

  // clamp run length, guard empty zones, form zone numerator
  always_comb begin
    run_len   = (pixel_count > plza_pkg::PIX_W'(plza_pkg::MAX_PIXELS)) ?
                plza_pkg::PIX_W'(plza_pkg::MAX_PIXELS) : pixel_count;
    mean_div  = (sum_count == '0) ? plza_pkg::PIX_W'(1) : sum_count;
    leds_p1   = {1'b0, led_count} + plza_pkg::LEDP_W'(1);
    prod_full = leds_p1 * pixel_index;
  end

  // steer divider operands
  always_comb begin
    case (cmd.div_sel)
      plza_pkg::DIV_ZONE: begin
        div_num = prod;
        div_den = run_len;
      end
      plza_pkg::DIV_RED: begin
        div_num = plza_pkg::NUM_W'(sum_red);
        div_den = mean_div;
      end
      plza_pkg::DIV_GREEN: begin
        div_num = plza_pkg::NUM_W'(sum_green);
        div_den = mean_div;
      end
      default: begin
        div_num = plza_pkg::NUM_W'(sum_blue);
        div_den = mean_div;
      end
    endcase
  end

  plza_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= plza_pkg::LED_COUNT_RST;
      pixel_count <= plza_pkg::PIXEL_COUNT_RST;
      byte_order  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plza_pkg::CFG_LED_COUNT:   led_count   <= cfg_data[plza_pkg::LED_W-1:0];
        plza_pkg::CFG_PIXEL_COUNT: pixel_count <= cfg_data;
        plza_pkg::CFG_BYTE_ORDER:  byte_order  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // run state: clear on run start, accumulate, drop sums at zone end
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index  <= '0;
      current_zone <= '0;
      sum_red      <= '0;
      sum_green    <= '0;
      sum_blue     <= '0;
      sum_count    <= '0;
    end else if (cmd.load) begin
      if (first_pixel) begin
        pixel_index  <= '0;
        current_zone <= '0;
        sum_red      <= '0;
        sum_green    <= '0;
        sum_blue     <= '0;
        sum_count    <= '0;
      end
    end else if (cmd.accum) begin
      sum_red     <= sat_add(sum_red, px_red);
      sum_green   <= sat_add(sum_green, px_green);
      sum_blue    <= sat_add(sum_blue, px_blue);
      sum_count   <= sum_count + 1'b1;
      pixel_index <= pixel_index + 1'b1;
    end else if (cmd.emit) begin
      sum_red      <= '0;
      sum_green    <= '0;
      sum_blue     <= '0;
      sum_count    <= '0;
      current_zone <= new_zone;
    end
  end

  // payload: split pixel channels, latch numerator, quotients and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_green <= pixel[15:8];
      px_red   <= byte_order ? pixel[23:16] : pixel[7:0];
      px_blue  <= byte_order ? pixel[7:0]   : pixel[23:16];
    end
    if (cmd.accum) begin
      prod <= prod_full[plza_pkg::NUM_W-1:0];
    end
    if (div_done) begin
      case (cmd.div_sel)
        plza_pkg::DIV_ZONE:  new_zone   <= quotient[plza_pkg::LED_W-1:0];
        plza_pkg::DIV_RED:   mean_red   <= quotient[plza_pkg::CH_W-1:0];
        plza_pkg::DIV_GREEN: mean_green <= quotient[plza_pkg::CH_W-1:0];
        default:             mean_blue  <= quotient[plza_pkg::CH_W-1:0];
      endcase
    end
    if (cmd.emit) begin
      led_index <= current_zone;
      led_color <= {mean_blue, mean_green, mean_red};
    end
  end

  always_comb begin
    sts.in_run       = pixel_index < run_len;
    sts.div_busy     = div_busy;
    sts.div_done     = div_done;
    sts.zone_differs = new_zone != current_zone;
  end

endmodule

// ----- rtl/plza_ctrl.sv -----
module plza_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  plza_pkg::dp_status_t  sts,
  output plza_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ZSTART,
    S_ZWAIT,
    S_ZCHECK,
    S_MSTART,
    S_MWAIT,
    S_EMIT
  } state_t;

  state_t             state;
  plza_pkg::div_sel_t sel;
  logic               in_beat;
  logic               out_beat;
  logic               out_free;

  always_comb begin
    in_stall = state != S_IDLE;
    in_beat  = in_valid && !in_stall;
    out_beat = out_valid && !out_stall;
    out_free = !out_valid || !out_stall;
  end

  // decode commands from state
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = plza_pkg::DIV_ZONE;
    unique case (state)
      S_IDLE:   cmd.load      = in_beat;
      S_CHECK:  cmd.accum     = sts.in_run;
      S_ZSTART: cmd.div_start = 1'b1;
      S_ZWAIT:  ;
      S_ZCHECK: ;
      S_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = sel;
      end
      S_MWAIT:  cmd.div_sel = sel;
      S_EMIT:   cmd.emit    = out_free;
      default:  ;
    endcase
  end

  // sequence one pixel; hold result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= plza_pkg::DIV_RED;
      out_valid <= 1'b0;
    end else begin
      // raise result valid on emit, drop it once the beat is taken
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_beat) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_CHECK;
          end
        end
        S_CHECK:  state <= sts.in_run ? S_ZSTART : S_IDLE;
        S_ZSTART: state <= S_ZWAIT;
        S_ZWAIT: begin
          if (sts.div_done) begin
            state <= S_ZCHECK;
          end
        end
        S_ZCHECK: begin
          sel   <= plza_pkg::DIV_RED;
          state <= sts.zone_differs ? S_MSTART : S_IDLE;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (sts.div_done) begin
            unique case (sel)
              plza_pkg::DIV_RED: begin
                sel   <= plza_pkg::DIV_GREEN;
                state <= S_MSTART;
              end
              plza_pkg::DIV_GREEN: begin
                sel   <= plza_pkg::DIV_BLUE;
                state <= S_MSTART;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plza_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 2000;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int INDEX_LIMIT   = (1 << PIX_W) - 1;

  typedef struct {
    logic [LED_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } zone_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [COLOR_W-1:0]    pixel;
  logic                  first_pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic [LED_W-1:0]      led_index;
  logic [COLOR_W-1:0]    led_color;

  // zone averages still owed by the block, oldest first
  zone_result_t pending_zones[$];

  // shadow of the configuration registers
  logic [LED_W-1:0] led_zones;
  logic [PIX_W-1:0] run_pixels;
  logic             red_high;

  // shadow of the accumulator state
  logic [PIX_W-1:0] run_pos;
  logic [LED_W-1:0] open_zone;
  logic [SUM_W-1:0] acc_red;
  logic [SUM_W-1:0] acc_green;
  logic [SUM_W-1:0] acc_blue;
  logic [PIX_W-1:0] acc_pixels;

  bit calm;
  int hold_request;
  int mismatches;
  int pixels_taken;
  int cycle_count;

  pixel_run_led_zone_averager uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .first_pixel (first_pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_index   (led_index),
    .led_color   (led_color)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_run();
    run_pos    = '0;
    open_zone  = '0;
    acc_red    = '0;
    acc_green  = '0;
    acc_blue   = '0;
    acc_pixels = '0;
  endfunction

  // Run length after the clamp to the pixel buffer and the index range
  function automatic int unsigned effective_span(input logic [PIX_W-1:0] count);
    int unsigned span;
    span = count;
    if (span > MAX_PIXELS) span = MAX_PIXELS;
    if (span > INDEX_LIMIT) span = INDEX_LIMIT;
    return span;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [CH_W-1:0] chan);
    logic [SUM_W:0] total;
    total = {1'b0, acc} + chan;
    return total[SUM_W] ? '1 : total[SUM_W-1:0];
  endfunction

  // Fold one pixel into the open zone; queue the zone average when it closes.
  // led_count cannot exceed the zone limit at its register width.
  task automatic average_pixel(input logic [COLOR_W-1:0] px, input logic first,
                               output bit in_run);
    int unsigned     span;
    int unsigned     divisor;
    longint unsigned num;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] mean_r;
    logic [CH_W-1:0] mean_g;
    logic [CH_W-1:0] mean_b;
    logic [LED_W-1:0] zone;
    zone_result_t    done;
    if (first) clear_run();
    span = effective_span(run_pixels);
    in_run = (run_pos < span);
    if (in_run) begin
      green = px[15:8];
      if (red_high) begin
        red  = px[23:16];
        blue = px[7:0];
      end else begin
        red  = px[7:0];
        blue = px[23:16];
      end
      acc_red    = sat_sum(acc_red, red);
      acc_green  = sat_sum(acc_green, green);
      acc_blue   = sat_sum(acc_blue, blue);
      acc_pixels = acc_pixels + 1'b1;
      num  = (longint'(led_zones) + 1) * longint'(run_pos);
      zone = LED_W'(num / span);
      run_pos = run_pos + 1'b1;
      if (zone != open_zone) begin
        divisor = (acc_pixels != 0) ? acc_pixels : 1;
        mean_r = CH_W'(acc_red / divisor);
        mean_g = CH_W'(acc_green / divisor);
        mean_b = CH_W'(acc_blue / divisor);
        done.index = open_zone;
        done.color = {mean_b, mean_g, mean_r};
        pending_zones.push_back(done);
        acc_red    = '0;
        acc_green  = '0;
        acc_blue   = '0;
        acc_pixels = '0;
        open_zone  = zone;
      end
    end
  endtask

  // Offer one pixel beat, with an occasional gap ahead of it
  task automatic send_pixel(input logic [COLOR_W-1:0] px, input logic first);
    bit in_run;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= px;
    first_pixel <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    average_pixel(px, first, in_run);
    if (in_run) pixels_taken++;
  endtask

  // Stop input, wait for every owed zone, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_zones.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back
  task automatic program_zones(input logic [CFG_DATA_W-1:0] leds_data,
                               input logic [CFG_DATA_W-1:0] pix_data,
                               input logic [CFG_DATA_W-1:0] order_data);
    logic [CFG_IDX_W-1:0]  regs[3];
    logic [CFG_DATA_W-1:0] vals[3];
    regs[0] = CFG_LED_COUNT;
    regs[1] = CFG_PIXEL_COUNT;
    regs[2] = CFG_BYTE_ORDER;
    vals[0] = leds_data;
    vals[1] = pix_data;
    vals[2] = order_data;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[k])
        CFG_LED_COUNT:   led_zones  = vals[k][LED_W-1:0];
        CFG_PIXEL_COUNT: run_pixels = vals[k][PIX_W-1:0];
        CFG_BYTE_ORDER:  red_high   = vals[k][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COLOR_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return COLOR_W'(32'hFF << (8 * $urandom_range(0, 2)));
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  // Sink side: check each zone beat and drive stall
  initial begin : zone_sink
    int burst_left;
    int hold_left;
    zone_result_t want;
    burst_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (pending_zones.size() == 0) begin
          $error("unexpected zone beat: led_index %0d led_color %06h", led_index, led_color);
          mismatches++;
        end else begin
          want = pending_zones.pop_front();
          if (led_index !== want.index) begin
            $error("led_index: expected %0d, got %0d", want.index, led_index);
            mismatches++;
          end
          if (led_color !== want.color) begin
            $error("led_color: expected %06h, got %06h", want.color, led_color);
            mismatches++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Pixels straight after reset, no run mark, default registers
  task automatic test_unmarked_start();
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h0000FF, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h808080, 1'b0);
    send_pixel(24'h010203, 1'b0);
    settle_block();
  endtask

  // Channel extremes in narrow zones, then pixels past the run end
  task automatic test_channel_extremes();
    program_zones(13'd3, 13'd8, 13'd0);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h0000FF, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hABCDEF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    settle_block();
  endtask

  // Swapped red and blue, with a restart mark in the middle of a run
  task automatic test_byte_order();
    program_zones(13'd3, 13'd8, 13'd1);
    send_pixel(24'hFF0000, 1'b1);
    send_pixel(24'h0000FF, 1'b0);
    send_pixel(24'hFF00FF, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h0000FF, 1'b1);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'h00FFFF, 1'b0);
    settle_block();
  endtask

  // A single zone, clamped run length, widest zone count, zero-length run
  task automatic test_run_bounds();
    program_zones(13'd0, 13'd4, 13'd0);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h000000, 1'b0);
    settle_block();
    program_zones(13'd1023, 13'd8191, 13'd1);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'hFEFEFE, 1'b0);
    send_pixel(24'h7F7F7F, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h800000, 1'b0);
    settle_block();
    program_zones(13'd5, 13'd0, 13'd0);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h123456, 1'b0);
    settle_block();
  endtask

  // Hold the sink off for a long stretch while pixels keep coming
  task automatic test_backpressure();
    program_zones(13'd63, 13'd32, 13'($urandom_range(0, 1)));
    hold_request = HOLD_CYCLES;
    for (int p = 0; p < 40; p++) send_pixel(random_pixel(), p == 0);
    settle_block();
  endtask

  // Random settings, mostly well-formed runs with some noise
  task automatic test_random_runs();
    int target;
    int span;
    int run_len;
    int extra;
    logic [CFG_DATA_W-1:0] leds_data;
    logic [CFG_DATA_W-1:0] pix_data;
    logic [CFG_DATA_W-1:0] order_data;
    logic first;
    target = pixels_taken + RANDOM_ITEMS;
    while (pixels_taken < target) begin
      calm = (pixels_taken >= target - 100) || ($urandom_range(0, 5) == 0);
      settle_block();
      case ($urandom_range(0, 7))
        0:       leds_data = {3'($urandom()), 10'd0};
        1:       leds_data = {3'($urandom()), 10'd1023};
        2, 3:    leds_data = CFG_DATA_W'($urandom());
        default: leds_data = {3'($urandom()), 10'($urandom_range(1, 63))};
      endcase
      case ($urandom_range(0, 9))
        0:       pix_data = '0;
        1:       pix_data = CFG_DATA_W'($urandom());
        2:       pix_data = 13'd4096;
        3:       pix_data = 13'd1;
        default: pix_data = 13'($urandom_range(2, 48));
      endcase
      order_data = CFG_DATA_W'($urandom());
      program_zones(leds_data, pix_data, order_data);
      span = effective_span(run_pixels);
      repeat ($urandom_range(1, 4)) begin
        run_len = (span > 48) ? $urandom_range(1, 48) : span;
        if (span > 48 && $urandom_range(0, 9) == 0) run_len = $urandom_range(49, 160);
        if (run_len == 0) run_len = $urandom_range(1, 3);
        for (int p = 0; p < run_len; p++) begin
          if (p == 0) first = ($urandom_range(0, 9) != 0);
          else first = ($urandom_range(0, 39) == 0);
          send_pixel(random_pixel(), first);
        end
        if ($urandom_range(0, 3) == 0) begin
          extra = $urandom_range(1, 3);
          repeat (extra) send_pixel(random_pixel(), 1'b0);
        end
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_LED_COUNT;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    pixel       <= '0;
    first_pixel <= 1'b0;
    calm         = 1'b0;
    hold_request = 0;
    mismatches   = 0;
    pixels_taken = 0;
    led_zones    = LED_COUNT_RST;
    run_pixels   = PIXEL_COUNT_RST;
    red_high     = 1'b0;
    clear_run();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unmarked_start();
    test_channel_extremes();
    test_byte_order();
    test_run_bounds();
    test_backpressure();
    test_random_runs();

    calm = 1'b1;
    settle_block();
    if (mismatches == 0 && pending_zones.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plza_pkg.sv
rtl/plza_div.sv
rtl/plza_datapath.sv
rtl/plza_ctrl.sv
rtl/pixel_run_led_zone_averager.sv
verif/tb_top.sv
